// ===== rtl/text_console_character_engine_macros.svh =====
// Assertion helpers for the console RTL, included by tcce_back.
// Both sample on clk_i; the first one is muted while rst_ni is low.
`ifndef TEXT_CONSOLE_CHARACTER_ENGINE_MACROS_SVH
`define TEXT_CONSOLE_CHARACTER_ENGINE_MACROS_SVH

`define TCCE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`define TCCE_ASSERT_ANY(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/tcce_pkg.sv =====
`default_nettype none

package tcce_pkg;

  localparam int ROWS     = 25;
  localparam int COLS     = 80;
  localparam int TAB_STEP = 8;
  localparam int CELLS    = ROWS * COLS;

  localparam int ADDR_W = $clog2(CELLS);
  localparam int CNT_W  = $clog2(CELLS + 1);
  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int CELL_W = 16;

  localparam int CFG_IDX_W = 1;

  localparam int CMDQ_DEPTH = 2;
  localparam int OUTQ_DEPTH = 2;

  localparam logic [CHAR_W-1:0] SPACE_CHAR     = 8'h20;
  localparam logic [ATTR_W-1:0] TEXT_ATTR_RST  = 8'd79;
  localparam logic [ATTR_W-1:0] BLANK_ATTR_RST = 8'd15;

  localparam logic [CHAR_W-1:0] CH_BS = 8'd8;
  localparam logic [CHAR_W-1:0] CH_HT = 8'd9;
  localparam logic [CHAR_W-1:0] CH_LF = 8'd10;
  localparam logic [CHAR_W-1:0] CH_FF = 8'd12;
  localparam logic [CHAR_W-1:0] CH_CR = 8'd13;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TEXT_ATTR,
    REG_BLANK_ATTR
  } cfg_idx_e;

  typedef enum logic [2:0] {
    OP_PRINT,
    OP_BS,
    OP_TAB,
    OP_NL,
    OP_FF,
    OP_CR,
    OP_READ,
    OP_READ_NONE
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [CHAR_W-1:0] char_code;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
  } cmd_t;

  typedef struct packed {
    logic [CELL_W-1:0] cell_val;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
  } res_t;

  typedef struct packed {
    logic [ATTR_W-1:0] text_attr;
    logic [ATTR_W-1:0] blank_attr;
  } attr_t;

  typedef logic [COLS-1:0][COL_W-1:0] tab_tbl_t;

  // Next tab stop for every column, clamped at the last column.
  function automatic tab_tbl_t build_tab();
    tab_tbl_t t;
    int       n;
    for (int i = 0; i < COLS; i++) begin
      n = (i / TAB_STEP + 1) * TAB_STEP;
      if (n > COLS - 1) n = COLS - 1;
      t[i] = COL_W'(n);
    end
    return t;
  endfunction

  localparam tab_tbl_t TAB_TBL = build_tab();

endpackage

`default_nettype wire

// ===== rtl/text_console_character_engine.sv =====
`default_nettype none

// Text console engine for an 80x25 character screen. Each input word either
// prints one byte at the cursor (func 0) or reads back one screen cell
// (func 1); every word yields exactly one result word holding the cell value
// (zero on a print) and the cursor position after the word. Bytes 8, 9, 10,
// 12 and 13 act as backspace, tab, newline, form feed and carriage return;
// every other byte is stored with the text attribute. Words enter a
// classifying front stage and a two-entry command queue; the back end owns
// the cursor and the 2000-entry cell memory (one write and one registered
// read port) and drops results into a two-entry result queue, so a finished
// word stalls intake only once the result queue, the command queue and the
// front stage have all backed up. In the back end, prints and cursor moves
// finish as they are decoded, a cell read adds a registered memory read,
// a form feed decodes, then writes one cell per cycle, and any move below
// the last row decodes, then scrolls with a row-ahead read and a trailing
// write per cycle through the single memory port pair. After reset the
// memory is swept to blanks while full stays high; configuration writes
// are taken at any time and should only be issued while the engine is
// idle.
module text_console_character_engine (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  // input words
  input  wire                               push,
  output logic                              full,
  input  wire                               func_i,
  input  wire [7:0]                         char_code_i,
  input  wire [4:0]                         read_row_i,
  input  wire [6:0]                         read_col_i,
  // result words
  output logic                              empty,
  input  wire                               pop,
  output logic [15:0]                       cell_value_o,
  output logic [4:0]                        cursor_row_o,
  output logic [6:0]                        cursor_col_o,
  // register writes
  input  wire                               cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire [tcce_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire [7:0]                         cfg_data_i
);
  import tcce_pkg::*;

  logic              busy;
  cmd_t              front_cmd, q_cmd;
  logic              front_vld, q_full, q_empty, q_pop;
  attr_t             attr;
  res_t              res;
  logic [ATTR_W-1:0] text_attr_q, text_attr_d;
  logic [ATTR_W-1:0] blank_attr_q, blank_attr_d;

  // Attribute registers; the register file never stalls a write.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    text_attr_d  = text_attr_q;
    blank_attr_d = blank_attr_q;
    if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        REG_TEXT_ATTR:  text_attr_d  = cfg_data_i;
        REG_BLANK_ATTR: blank_attr_d = cfg_data_i;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_attr_q  <= TEXT_ATTR_RST;
      blank_attr_q <= BLANK_ATTR_RST;
    end else begin
      text_attr_q  <= text_attr_d;
      blank_attr_q <= blank_attr_d;
    end
  end

  assign attr.text_attr  = text_attr_q;
  assign attr.blank_attr = blank_attr_q;

  // Front: register and classify each word; hold intake during the reset sweep.
  tcce_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .func_i      (func_i),
    .char_code_i (char_code_i),
    .read_row_i  (read_row_i),
    .read_col_i  (read_col_i),
    .hold_i      (busy),
    .cmd_o       (front_cmd),
    .cmd_vld_o   (front_vld),
    .cmd_full_i  (q_full)
  );

  // Decouple the front from long scroll and clear runs.
  tcce_cmdq u_cmdq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_vld),
    .data_i  (front_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_cmd),
    .empty_o (q_empty)
  );

  // Back: cursor, cell memory, scroll/clear sequencer and result queue.
  tcce_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (q_cmd),
    .cmd_vld_i   (!q_empty),
    .cmd_pop_o   (q_pop),
    .attr_i      (attr),
    .busy_o      (busy),
    .res_o       (res),
    .res_empty_o (empty),
    .res_pop_i   (pop)
  );

  assign cell_value_o = res.cell_val;
  assign cursor_row_o = res.row;
  assign cursor_col_o = res.col;

endmodule

`default_nettype wire

// ===== rtl/tcce_front.sv =====
`default_nettype none

module tcce_front (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   push_i,
  output logic                  full_o,
  input  wire                   func_i,
  input  wire [7:0]             char_code_i,
  input  wire [4:0]             read_row_i,
  input  wire [6:0]             read_col_i,
  input  wire                   hold_i,
  output tcce_pkg::cmd_t        cmd_o,
  output logic                  cmd_vld_o,
  input  wire                   cmd_full_i
);
  import tcce_pkg::*;

  logic vld_q, vld_d;
  cmd_t cmd_q, cmd_d;
  logic accept, fwd;

  assign fwd    = vld_q && !cmd_full_i;
  assign full_o = hold_i || (vld_q && cmd_full_i);
  assign accept = push_i && !full_o;

  // Classify the word.
  always_comb begin
    cmd_d.char_code = char_code_i;
    cmd_d.row       = read_row_i;
    cmd_d.col       = read_col_i;
    if (func_i) begin
      if ((read_row_i < ROW_W'(ROWS)) && (read_col_i < COL_W'(COLS))) cmd_d.op = OP_READ;
      else cmd_d.op = OP_READ_NONE;
    end else begin
      unique case (char_code_i)
        CH_BS:   cmd_d.op = OP_BS;
        CH_HT:   cmd_d.op = OP_TAB;
        CH_LF:   cmd_d.op = OP_NL;
        CH_FF:   cmd_d.op = OP_FF;
        CH_CR:   cmd_d.op = OP_CR;
        default: cmd_d.op = OP_PRINT;
      endcase
    end
  end

  always_comb begin
    vld_d = vld_q;
    if (fwd || !vld_q) vld_d = accept;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) cmd_q <= cmd_d;
  end

  assign cmd_o     = cmd_q;
  assign cmd_vld_o = vld_q;

endmodule

`default_nettype wire

// ===== rtl/tcce_cmdq.sv =====
`default_nettype none

module tcce_cmdq (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             push_i,
  input  tcce_pkg::cmd_t  data_i,
  output logic            full_o,
  input  wire             pop_i,
  output tcce_pkg::cmd_t  data_o,
  output logic            empty_o
);
  import tcce_pkg::*;

  localparam int PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int QCNT_W = $clog2(CMDQ_DEPTH + 1);

  cmd_t              mem_q [CMDQ_DEPTH];
  logic [PTR_W-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == QCNT_W'(CMDQ_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) wr_d = (wr_q == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_q + 1'b1;
    if (do_pop)  rd_d = (rd_q == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    if (do_push && !do_pop) cnt_d = cnt_q + 1'b1;
    else if (do_pop && !do_push) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= data_i;
  end

endmodule

`default_nettype wire

// ===== rtl/tcce_back.sv =====
`default_nettype none
`include "text_console_character_engine_macros.svh"

module tcce_back (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  tcce_pkg::cmd_t   cmd_i,
  input  wire              cmd_vld_i,
  output logic             cmd_pop_o,
  input  tcce_pkg::attr_t  attr_i,
  output logic             busy_o,
  output tcce_pkg::res_t   res_o,
  output logic             res_empty_o,
  input  wire              res_pop_i
);
  import tcce_pkg::*;

  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_RD   = 3'd2;
  localparam logic [2:0] ST_SCR  = 3'd3;
  localparam logic [2:0] ST_FILL = 3'd4;

  localparam int OQ_PTR_W = (OUTQ_DEPTH > 1) ? $clog2(OUTQ_DEPTH) : 1;
  localparam int OQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

  logic [2:0]        st_q, st_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [ROW_W-1:0]  cur_row_q, cur_row_d;
  logic [COL_W-1:0]  cur_col_q, cur_col_d;

  logic [CELL_W-1:0] mem_q [CELLS];
  logic [CELL_W-1:0] rdata_q;
  logic              we, re;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [CELL_W-1:0] wdata;

  logic [ADDR_W-1:0] cur_addr, rd_addr;
  logic [CELL_W-1:0] blank, cell_sel;
  logic              last_row, last_col, room;

  res_t                oq_q [OUTQ_DEPTH];
  logic [OQ_PTR_W-1:0] oq_wr_q, oq_wr_d, oq_rd_q, oq_rd_d;
  logic [OQ_CNT_W-1:0] oq_cnt_q, oq_cnt_d;
  logic                res_push, res_pop;
  res_t                res_data;

  assign cur_addr = ADDR_W'(cur_row_q) * ADDR_W'(COLS) + ADDR_W'(cur_col_q);
  assign rd_addr  = ADDR_W'(cmd_i.row) * ADDR_W'(COLS) + ADDR_W'(cmd_i.col);
  assign blank    = {attr_i.blank_attr, SPACE_CHAR};
  assign last_row = (cur_row_q == ROW_W'(ROWS - 1));
  assign last_col = (cur_col_q == COL_W'(COLS - 1));
  assign room     = (oq_cnt_q != OQ_CNT_W'(OUTQ_DEPTH));

  always_comb begin
    st_d      = st_q;
    cnt_d     = cnt_q;
    cur_row_d = cur_row_q;
    cur_col_d = cur_col_q;
    we        = 1'b0;
    waddr     = '0;
    wdata     = '0;
    re        = 1'b0;
    raddr     = '0;
    cmd_pop_o = 1'b0;
    res_push  = 1'b0;
    cell_sel  = '0;
    unique case (st_q)
      ST_CLR, ST_FILL: begin
        we    = 1'b1;
        waddr = cnt_q[ADDR_W-1:0];
        wdata = (st_q == ST_CLR) ? {BLANK_ATTR_RST, SPACE_CHAR} : blank;
        if (cnt_q == CNT_W'(CELLS - 1)) begin
          cnt_d    = '0;
          st_d     = ST_IDLE;
          res_push = (st_q == ST_FILL);
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_IDLE: begin
        if (cmd_vld_i && room) begin
          cmd_pop_o = 1'b1;
          unique case (cmd_i.op)
            OP_PRINT: begin
              we    = 1'b1;
              waddr = cur_addr;
              wdata = {attr_i.text_attr, cmd_i.char_code};
              if (last_col) begin
                cur_col_d = '0;
                if (last_row) begin
                  st_d  = ST_SCR;
                  cnt_d = '0;
                end else begin
                  cur_row_d = cur_row_q + 1'b1;
                  res_push  = 1'b1;
                end
              end else begin
                cur_col_d = cur_col_q + 1'b1;
                res_push  = 1'b1;
              end
            end
            OP_BS: begin
              if (cur_col_q != '0) cur_col_d = cur_col_q - 1'b1;
              res_push = 1'b1;
            end
            OP_TAB: begin
              cur_col_d = TAB_TBL[cur_col_q];
              res_push  = 1'b1;
            end
            OP_NL: begin
              cur_col_d = '0;
              if (last_row) begin
                st_d  = ST_SCR;
                cnt_d = '0;
              end else begin
                cur_row_d = cur_row_q + 1'b1;
                res_push  = 1'b1;
              end
            end
            OP_FF: begin
              cur_row_d = '0;
              cur_col_d = '0;
              cnt_d     = '0;
              st_d      = ST_FILL;
            end
            OP_CR: begin
              cur_col_d = '0;
              res_push  = 1'b1;
            end
            OP_READ: begin
              re    = 1'b1;
              raddr = rd_addr;
              st_d  = ST_RD;
            end
            OP_READ_NONE: begin
              res_push = 1'b1;
            end
          endcase
        end
      end
      ST_RD: begin
        cell_sel = rdata_q;
        res_push = 1'b1;
        st_d     = ST_IDLE;
      end
      ST_SCR: begin
        // Read one row ahead, write the word read last cycle one slot behind.
        if (cnt_q < CNT_W'(CELLS - COLS)) begin
          re    = 1'b1;
          raddr = ADDR_W'(cnt_q + CNT_W'(COLS));
        end
        if (cnt_q != '0) begin
          we    = 1'b1;
          waddr = ADDR_W'(cnt_q - 1'b1);
          wdata = (cnt_q <= CNT_W'(CELLS - COLS)) ? rdata_q : blank;
        end
        if (cnt_q == CNT_W'(CELLS)) begin
          cnt_d    = '0;
          st_d     = ST_IDLE;
          res_push = 1'b1;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_comb begin
    res_data.cell_val = cell_sel;
    res_data.row      = cur_row_d;
    res_data.col      = cur_col_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= ST_CLR;
      cnt_q     <= '0;
      cur_row_q <= '0;
      cur_col_q <= '0;
    end else begin
      st_q      <= st_d;
      cnt_q     <= cnt_d;
      cur_row_q <= cur_row_d;
      cur_col_q <= cur_col_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= wdata;
    if (re) rdata_q <= mem_q[raddr];
  end

  // Result queue.
  assign res_pop     = res_pop_i && (oq_cnt_q != '0);
  assign res_empty_o = (oq_cnt_q == '0);
  assign res_o       = oq_q[oq_rd_q];

  always_comb begin
    oq_wr_d  = oq_wr_q;
    oq_rd_d  = oq_rd_q;
    oq_cnt_d = oq_cnt_q;
    if (res_push) oq_wr_d = (oq_wr_q == OQ_PTR_W'(OUTQ_DEPTH - 1)) ? '0 : oq_wr_q + 1'b1;
    if (res_pop)  oq_rd_d = (oq_rd_q == OQ_PTR_W'(OUTQ_DEPTH - 1)) ? '0 : oq_rd_q + 1'b1;
    if (res_push && !res_pop) oq_cnt_d = oq_cnt_q + 1'b1;
    else if (res_pop && !res_push) oq_cnt_d = oq_cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oq_wr_q  <= '0;
      oq_rd_q  <= '0;
      oq_cnt_q <= '0;
    end else begin
      oq_wr_q  <= oq_wr_d;
      oq_rd_q  <= oq_rd_d;
      oq_cnt_q <= oq_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_push) oq_q[oq_wr_q] <= res_data;
  end

  assign busy_o = (st_q == ST_CLR);

  `TCCE_ASSERT(a_cursor_on_screen, (cur_row_q < ROW_W'(ROWS)) && (cur_col_q < COL_W'(COLS)), "cursor off screen")
  `TCCE_ASSERT(a_outq_bound, oq_cnt_q <= OQ_CNT_W'(OUTQ_DEPTH), "result queue overflow")
  `TCCE_ASSERT(a_read_one_cycle, (st_q == ST_RD) |=> (st_q == ST_IDLE), "read took more than one cycle")
  `TCCE_ASSERT(a_pop_needs_room, cmd_pop_o |-> (st_q == ST_IDLE) && room, "command taken without result room")
  `TCCE_ASSERT_ANY(a_no_pop_clearing, busy_o |-> !cmd_pop_o && !res_push, "work done during clear")

endmodule

`default_nettype wire

// ===== tb/sv/text_console_character_engine_tb.sv =====
`default_nettype none

module text_console_character_engine_tb;

  import tcce_pkg::*;

  // Input word function codes.
  localparam logic FUNC_PUT  = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  // A scroll walks the whole store, so give the engine that long (plus margin)
  // to go quiet before touching the attribute registers or ending the run.
  localparam int DRAIN_CYCLES = 2100;
  localparam int LIMIT_CYCLES = 12_000_000;
  localparam int LONG_HOLD    = 400;
  localparam int HOLD_AT_WORD = 400;
  localparam int SCRIPT_LEN   = 24;

  // Clock and reset.
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Stimulus side.
  logic       push        = 1'b0;
  logic       func_i      = 1'b0;
  logic [7:0] char_code_i = 8'h00;
  logic [4:0] read_row_i  = 5'd0;
  logic [6:0] read_col_i  = 7'd0;
  logic       pop         = 1'b0;
  logic       cfg_valid_i = 1'b0;
  cfg_idx_e   cfg_index_i = REG_TEXT_ATTR;
  logic [7:0] cfg_data_i  = 8'h00;

  // Observed side.
  logic        full;
  logic        empty;
  logic [15:0] cell_value_o;
  logic [4:0]  cursor_row_o;
  logic [6:0]  cursor_col_o;
  logic        cfg_ready_o;

  text_console_character_engine dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .func_i       (func_i),
    .char_code_i  (char_code_i),
    .read_row_i   (read_row_i),
    .read_col_i   (read_col_i),
    .empty        (empty),
    .pop          (pop),
    .cell_value_o (cell_value_o),
    .cursor_row_o (cursor_row_o),
    .cursor_col_o (cursor_col_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  // ---------------------------------------------------------------------------
  // Screen mirror: our own copy of the cell store, cursor and attributes.
  // ---------------------------------------------------------------------------
  logic [15:0] screen_mirror [CELLS];
  int          crs_row;
  int          crs_col;
  logic [7:0]  text_attr  = TEXT_ATTR_RST;
  logic [7:0]  blank_attr = BLANK_ATTR_RST;

  // Results still owed by the engine, oldest first.
  res_t        awaited_words [$];
  int          mismatches   = 0;
  int          words_out    = 0;
  bit          steady       = 1'b0;

  function automatic void blank_screen();
    for (int i = 0; i < CELLS; i++) screen_mirror[i] = {blank_attr, SPACE_CHAR};
  endfunction

  // Drop to column 0 of the next row; at the bottom shift every row up one
  // and fill the freed bottom row with blanks.
  function automatic void line_feed();
    crs_col = 0;
    if (crs_row + 1 >= ROWS) begin
      for (int i = 0; i + COLS < CELLS; i++) screen_mirror[i] = screen_mirror[i + COLS];
      for (int i = CELLS - COLS; i < CELLS; i++) screen_mirror[i] = {blank_attr, SPACE_CHAR};
      crs_row = ROWS - 1;
    end else begin
      crs_row++;
    end
  endfunction

  // Apply one input word to the mirror and return the result word it yields.
  function automatic res_t console_step(logic f, logic [7:0] code,
                                        logic [4:0] rr, logic [6:0] rc);
    res_t r;
    int   stop;
    r = '0;
    if (f == FUNC_PUT) begin
      case (code)
        CH_BS: begin
          if (crs_col != 0) crs_col--;
        end
        CH_HT: begin
          stop = (crs_col / TAB_STEP + 1) * TAB_STEP;
          if (stop > COLS - 1) stop = COLS - 1;
          crs_col = stop;
        end
        CH_LF: begin
          line_feed();
        end
        CH_FF: begin
          blank_screen();
          crs_row = 0;
          crs_col = 0;
        end
        CH_CR: begin
          crs_col = 0;
        end
        default: begin
          // Any other byte, control bytes included, prints as a glyph.
          screen_mirror[crs_row * COLS + crs_col] = {text_attr, code};
          if (crs_col + 1 >= COLS) line_feed();
          else crs_col++;
        end
      endcase
    end else if (rr < ROWS && rc < COLS) begin
      r.cell_val = screen_mirror[rr * COLS + rc];
    end
    // Reads outside the screen answer zero and leave the cursor alone.
    r.row = crs_row[4:0];
    r.col = crs_col[6:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Directed script. Typed expectations sit only where they are obvious; the
  // mirror supplies the rest. With reps > 1 the typed value covers the last
  // repetition.
  // ---------------------------------------------------------------------------
  typedef struct packed {
    logic        func;
    logic [7:0]  code;
    logic [4:0]  rr;
    logic [6:0]  rc;
    logic [7:0]  reps;
    logic        typed;
    logic [15:0] cell_val;
    logic [4:0]  row;
    logic [6:0]  col;
  } script_row_t;

  script_row_t script [SCRIPT_LEN] = '{
    // Fresh screen: blanks with the reset blank attribute.
    '{FUNC_READ, 8'h00,  5'd0,  7'd0,   8'd1,  1'b1, 16'h0F20, 5'd0,  7'd0},
    '{FUNC_READ, 8'h00,  5'd24, 7'd79,  8'd1,  1'b1, 16'h0F20, 5'd0,  7'd0},
    // Reads off the screen answer zero.
    '{FUNC_READ, 8'hFF,  5'd31, 7'd127, 8'd1,  1'b1, 16'h0000, 5'd0,  7'd0},
    '{FUNC_READ, 8'h00,  5'd25, 7'd0,   8'd1,  1'b1, 16'h0000, 5'd0,  7'd0},
    '{FUNC_READ, 8'h00,  5'd0,  7'd80,  8'd1,  1'b1, 16'h0000, 5'd0,  7'd0},
    // Print, read back with the text attribute.
    '{FUNC_PUT,  8'h41,  5'd0,  7'd0,   8'd1,  1'b1, 16'h0000, 5'd0,  7'd1},
    '{FUNC_READ, 8'h00,  5'd0,  7'd0,   8'd1,  1'b1, 16'h4F41, 5'd0,  7'd1},
    // Backspace, then backspace stuck at column 0.
    '{FUNC_PUT,  CH_BS,  5'd0,  7'd0,   8'd1,  1'b1, 16'h0000, 5'd0,  7'd0},
    '{FUNC_PUT,  CH_BS,  5'd0,  7'd0,   8'd1,  1'b1, 16'h0000, 5'd0,  7'd0},
    '{FUNC_PUT,  CH_HT,  5'd0,  7'd0,   8'd1,  1'b1, 16'h0000, 5'd0,  7'd8},
    // Byte extremes and a non-handled control byte print as glyphs.
    '{FUNC_PUT,  8'hFF,  5'd0,  7'd0,   8'd1,  1'b1, 16'h0000, 5'd0,  7'd9},
    '{FUNC_PUT,  8'h00,  5'd0,  7'd0,   8'd1,  1'b1, 16'h0000, 5'd0,  7'd10},
    '{FUNC_PUT,  8'h0B,  5'd0,  7'd0,   8'd1,  1'b1, 16'h0000, 5'd0,  7'd11},
    '{FUNC_PUT,  CH_CR,  5'd0,  7'd0,   8'd1,  1'b1, 16'h0000, 5'd0,  7'd0},
    // Tab across the line up to the clamp, then tab at the clamp.
    '{FUNC_PUT,  CH_HT,  5'd0,  7'd0,   8'd10, 1'b1, 16'h0000, 5'd0,  7'd79},
    '{FUNC_PUT,  CH_HT,  5'd0,  7'd0,   8'd1,  1'b1, 16'h0000, 5'd0,  7'd79},
    // Print at the last column wraps to the next row.
    '{FUNC_PUT,  8'h5A,  5'd0,  7'd0,   8'd1,  1'b1, 16'h0000, 5'd1,  7'd0},
    '{FUNC_READ, 8'h00,  5'd0,  7'd79,  8'd1,  1'b1, 16'h4F5A, 5'd1,  7'd0},
    // Walk to the bottom; the last newline scrolls.
    '{FUNC_PUT,  CH_LF,  5'd0,  7'd0,   8'd24, 1'b1, 16'h0000, 5'd24, 7'd0},
    // Fill the bottom row; the wrap scrolls it up one row.
    '{FUNC_PUT,  8'h42,  5'd0,  7'd0,   8'd80, 1'b1, 16'h0000, 5'd24, 7'd0},
    '{FUNC_READ, 8'h00,  5'd23, 7'd0,   8'd1,  1'b1, 16'h4F42, 5'd24, 7'd0},
    '{FUNC_READ, 8'h00,  5'd24, 7'd5,   8'd1,  1'b1, 16'h0F20, 5'd24, 7'd0},
    // Form feed clears and homes.
    '{FUNC_PUT,  CH_FF,  5'd0,  7'd0,   8'd1,  1'b1, 16'h0000, 5'd0,  7'd0},
    '{FUNC_READ, 8'h00,  5'd23, 7'd0,   8'd1,  1'b1, 16'h0F20, 5'd0,  7'd0}
  };

  // ---------------------------------------------------------------------------
  // Sender helpers. Drive on the falling edge, sample on the rising edge.
  // ---------------------------------------------------------------------------

  // Offer one word, hold it until taken, then record what it owes.
  task automatic push_word(logic f, logic [7:0] code, logic [4:0] rr,
                           logic [6:0] rc, bit typed, res_t given);
    res_t owed;
    @(negedge clk_i);
    push        <= 1'b1;
    func_i      <= f;
    char_code_i <= code;
    read_row_i  <= rr;
    read_col_i  <= rc;
    do @(posedge clk_i); while (full);
    owed = console_step(f, code, rr, rc);
    awaited_words.push_back(typed ? given : owed);
  endtask

  // Hold push low; n gives the length of the idle stretch.
  task automatic idle_in(int n);
    repeat (n) begin
      @(negedge clk_i);
      push <= 1'b0;
    end
  endtask

  task automatic maybe_gap();
    if (!steady && $urandom_range(0, 3) == 0) idle_in($urandom_range(1, 11));
  endtask

  // Stop offering, wait out every owed word, then let a full scroll finish.
  task automatic drain();
    @(negedge clk_i);
    push <= 1'b0;
    while (awaited_words.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [7:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == REG_TEXT_ATTR) text_attr = val;
    else blank_attr = val;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // One random word: mostly prints with a healthy share of cursor moves, a
  // rare form feed, and reads that sometimes fall off the screen.
  task automatic random_word();
    int         pick;
    logic [7:0] code;
    logic [4:0] rr;
    logic [6:0] rc;
    pick = $urandom_range(0, 999);
    code = 8'($urandom_range(0, 255));
    rr   = 5'(($urandom_range(0, 6) == 0) ? $urandom_range(0, 31)
                                          : $urandom_range(0, ROWS - 1));
    rc   = 7'(($urandom_range(0, 6) == 0) ? $urandom_range(0, 127)
                                          : $urandom_range(0, COLS - 1));
    if (pick < 200) begin
      push_word(FUNC_READ, code, rr, rc, 1'b0, '0);
    end else begin
      if (pick < 250) code = CH_LF;
      else if (pick < 280) code = CH_CR;
      else if (pick < 310) code = CH_BS;
      else if (pick < 340) code = CH_HT;
      else if (pick < 347) code = CH_FF;
      push_word(FUNC_PUT, code, rr, rc, 1'b0, '0);
    end
  endtask

  task automatic random_phase(int n, logic [7:0] ta, logic [7:0] ba);
    drain();
    write_reg(REG_TEXT_ATTR, ta);
    write_reg(REG_BLANK_ATTR, ba);
    repeat (n) begin
      maybe_gap();
      random_word();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  initial begin
    crs_row = 0;
    crs_col = 0;
    blank_screen();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed script; words wait on full, so the clearing sweep is covered.
    foreach (script[i]) begin
      for (int k = 0; k < script[i].reps; k++) begin
        maybe_gap();
        push_word(script[i].func, script[i].code, script[i].rr, script[i].rc,
                  script[i].typed && (k == script[i].reps - 1),
                  '{cell_val: script[i].cell_val, row: script[i].row,
                    col: script[i].col});
      end
    end

    // Random phases, attribute extremes first.
    random_phase(300, 8'h00, 8'hFF);
    random_phase(300, 8'hFF, 8'h00);
    random_phase(300, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));

    // Final stretch at full rate on both sides.
    drain();
    steady = 1'b1;
    random_phase(200, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));

    drain();
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, one long hold-off to back the engine up.
  // ---------------------------------------------------------------------------
  initial begin
    int  hold_left;
    bit  long_done;
    hold_left = 0;
    long_done = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!long_done && words_out >= HOLD_AT_WORD) begin
        // Hold pop low long enough for both queues to fill and full to rise.
        long_done = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (!steady && $urandom_range(0, 5) == 0) begin
        hold_left = $urandom_range(1, 11) - 1;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checking.
  // ---------------------------------------------------------------------------
  task automatic check_field(string what, logic [15:0] got, logic [15:0] want);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && pop && !empty) begin
      words_out++;
      if (awaited_words.size() == 0) begin
        $display("%0t: unexpected result word, expected none, got cell %0h row %0d col %0d",
                 $time, cell_value_o, cursor_row_o, cursor_col_o);
        mismatches++;
      end else begin
        want = awaited_words.pop_front();
        check_field("cell_value", cell_value_o, want.cell_val);
        check_field("cursor_row", 16'(cursor_row_o), 16'(want.row));
        check_field("cursor_col", 16'(cursor_col_o), 16'(want.col));
      end
    end
  end

  // Watchdog.
  initial begin
    int cycles;
    cycles = 0;
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("%0t: timeout with %0d result words outstanding", $time, awaited_words.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule

`default_nettype wire
